[rtl/assert_macros.svh]
// Assertion macros for the face normal RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define TFN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also active during reset.
`define TFN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/tfn_pkg.sv]
// Types and constants for the triangle face normal pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
  localparam int COORD_BITS  = 24;
  localparam int NORMAL_BITS = 16;

  // Edge, product and cross product widths.
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int POS_W   = $clog2(CROSS_W);
  // The largest normalized magnitude lies in [2^23, 2^24).
  localparam int MAG_W   = 24;
  localparam int SQ_W    = 2 * MAG_W + 2;
  localparam int RAD_W   = SQ_W + 12;
  localparam int ROOT_W  = RAD_W / 2;
  // Division: numerator = mag * 2^(NORMAL_BITS+6) + len, divisor = 2 * len.
  localparam int NUM_W   = MAG_W + NORMAL_BITS + 7;
  localparam int Q_W     = NORMAL_BITS + 1;
  localparam int DIV_W   = ROOT_W + 1;
  localparam int CMP_W   = DIV_W + Q_W;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;
  } out_word_t;

  // Data that rides along with the square root and the division.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  degen;
  } side_t;
endpackage
`default_nettype wire

[rtl/tfn_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_isqrt
  import tfn_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  input  wire side_t             side_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);
  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  side_t             side_q [ROOT_W];
  logic [ROOT_W-1:0] vld_q;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [63:0]       trial;
    logic [RAD_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    // Test (2r + 2^k) * 2^k against the remainder.
    always_comb begin
      trial = ({{(64-ROOT_W){1'b0}}, root_in} << (K + 1)) + (64'd1 << (2 * K));
      if ({{(64-RAD_W){1'b0}}, rem_in} >= trial) begin
        rem_d  = rem_in - trial[RAD_W-1:0];
        root_d = root_in | (ROOT_W'(1) << K);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        side_q[j] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];
endmodule
`default_nettype wire

[rtl/tfn_div.sv]
// Pipelined restoring divider for the three normal components, one quotient
// bit per stage, sharing one divisor. Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_div
  import tfn_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [ROOT_W-1:0] len_i,
  input  wire side_t             side_i,
  output logic                   valid_o,
  output logic [2:0][Q_W-1:0]    quo_o,
  output side_t                  side_o
);
  logic [2:0][NUM_W-1:0] rem_q [Q_W];
  logic [2:0][Q_W-1:0]   quo_q [Q_W];
  logic [DIV_W-1:0]      div_q [Q_W];
  side_t                 side_q [Q_W];
  logic [Q_W-1:0]        vld_q;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int B = Q_W - 1 - j;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][Q_W-1:0]   quo_in;
    logic [DIV_W-1:0]      div_in;
    side_t                 side_in;
    logic [CMP_W-1:0]      dsh;
    logic [2:0][NUM_W-1:0] rem_d;
    logic [2:0][Q_W-1:0]   quo_d;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {side_i.mag[i], {(NORMAL_BITS+6){1'b0}}} + NUM_W'(len_i);
        end
      end
      assign quo_in  = '0;
      assign div_in  = {len_i, 1'b0};
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign div_in  = div_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      dsh = {{Q_W{1'b0}}, div_in} << B;
      for (int i = 0; i < 3; i++) begin
        if (CMP_W'(rem_in[i]) >= dsh) begin
          rem_d[i] = rem_in[i] - dsh[NUM_W-1:0];
          quo_d[i] = quo_in[i] | (Q_W'(1) << B);
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = quo_in[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        div_q[j]  <= div_in;
        side_q[j] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];
endmodule
`default_nettype wire

[rtl/triangle_face_normal.sv]
// Triangle face normal: edges, cross product, normalization to unit length.
// Depends on tfn_pkg, tfn_isqrt, tfn_div and assert_macros.svh.
//
// Use: present one triangle per word on in_word_i with in_valid_i; the word
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// One normal word per triangle leaves on out_word_o with out_valid_o, in
// order, and is taken when out_stall_i is low.
// Throughput is one triangle per cycle while the output is not stalled. From
// the accepting edge to out_valid_o a word passes seven front stages (edges,
// products, cross product, leading-one search, normalize, squares, sum), 31
// stages of the square root at one root bit each, 17 stages of the divider at
// one quotient bit each, and the output register; the square root is deepest.
// A degenerate triangle (zero cross product) gives a zero normal with the
// degenerate flag set. Components at +1.0 saturate to the largest Q1.15 value.
// Reset clears all valid bits; the pipeline then holds no words.
// When the receiver stalls a valid output word, the whole pipeline freezes
// and in_stall_o rises, so no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module triangle_face_normal
  import tfn_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);
  // The pipeline advances unless a finished word waits at the output.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: edge vectors B-A and C-A.
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic                     v1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= EDGE_W'(in_word_i.b_x) - EDGE_W'(in_word_i.a_x);
      e1_q[1] <= EDGE_W'(in_word_i.b_y) - EDGE_W'(in_word_i.a_y);
      e1_q[2] <= EDGE_W'(in_word_i.b_z) - EDGE_W'(in_word_i.a_z);
      e2_q[0] <= EDGE_W'(in_word_i.c_x) - EDGE_W'(in_word_i.a_x);
      e2_q[1] <= EDGE_W'(in_word_i.c_y) - EDGE_W'(in_word_i.a_y);
      e2_q[2] <= EDGE_W'(in_word_i.c_z) - EDGE_W'(in_word_i.a_z);
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic signed [PROD_W-1:0] pr_q [6];
  logic                     v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0] <= e1_q[1] * e2_q[2];
      pr_q[1] <= e1_q[2] * e2_q[1];
      pr_q[2] <= e1_q[2] * e2_q[0];
      pr_q[3] <= e1_q[0] * e2_q[2];
      pr_q[4] <= e1_q[0] * e2_q[1];
      pr_q[5] <= e1_q[1] * e2_q[0];
    end
  end

  // Stage 3: cross product split into sign and magnitude.
  logic [CROSS_W-1:0] cm_d [3];
  logic [2:0]         cn_d;
  logic [CROSS_W-1:0] cm_q [3];
  logic [2:0]         cn_q;
  logic               cdeg_q;
  logic               v3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [CROSS_W-1:0] n;
      n       = CROSS_W'(pr_q[2*i]) - CROSS_W'(pr_q[2*i+1]);
      cn_d[i] = n[CROSS_W-1];
      cm_d[i] = n[CROSS_W-1] ? CROSS_W'(-n) : CROSS_W'(n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm_q   <= cm_d;
      cn_q   <= cn_d;
      cdeg_q <= (cm_d[0] == '0) && (cm_d[1] == '0) && (cm_d[2] == '0);
    end
  end

  // Stage 4: position of the leading one of the largest magnitude. The
  // leading one of the OR of the magnitudes is that of their maximum.
  logic [CROSS_W-1:0] any_one;
  logic [POS_W-1:0]   lead_d;
  logic [CROSS_W-1:0] lm_q [3];
  logic [2:0]         ln_q;
  logic               ldeg_q;
  logic [POS_W-1:0]   lead_q;
  logic               v4_q;

  always_comb begin
    any_one = cm_q[0] | cm_q[1] | cm_q[2];
    lead_d  = '0;
    for (int b = 0; b < CROSS_W; b++) begin
      if (any_one[b]) begin
        lead_d = POS_W'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lm_q   <= cm_q;
      ln_q   <= cn_q;
      ldeg_q <= cdeg_q;
      lead_q <= lead_d;
    end
  end

  // Stage 5: shift the magnitudes so that the largest lies in [2^23, 2^24).
  // Bits shifted out on the right are dropped.
  side_t nm_q;
  logic  v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [CROSS_W+MAG_W-2:0] wide;
        wide         = {lm_q[i], {(MAG_W-1){1'b0}}} >> lead_q;
        nm_q.mag[i] <= wide[MAG_W-1:0];
      end
      nm_q.neg   <= ln_q;
      nm_q.degen <= ldeg_q;
    end
  end

  // Stage 6: squares of the normalized magnitudes.
  logic [2*MAG_W-1:0] sq_q [3];
  side_t              sq_side_q;
  logic               v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= nm_q.mag[i] * nm_q.mag[i];
      end
      sq_side_q <= nm_q;
    end
  end

  // Stage 7: sum of squares.
  logic [SQ_W-1:0] sum_q;
  side_t           sum_side_q;
  logic            v7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q      <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
      sum_side_q <= sq_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // Length times 64: floor(sqrt(sum * 2^12)).
  logic              sr_valid;
  logic [ROOT_W-1:0] sr_len;
  side_t             sr_side;

  tfn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .rad_i   ({sum_q, 12'd0}),
    .side_i  (sum_side_q),
    .valid_o (sr_valid),
    .root_o  (sr_len),
    .side_o  (sr_side)
  );

  // Rounded quotients mag * 2^15 / length.
  logic                dv_valid;
  logic [2:0][Q_W-1:0] dv_quo;
  side_t               dv_side;

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sr_valid),
    .len_i   (sr_len),
    .side_i  (sr_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Output register: saturate, restore the sign, zero a degenerate normal.
  localparam logic [Q_W-1:0] PosMax = Q_W'((1 << (NORMAL_BITS - 1)) - 1);
  localparam logic [Q_W-1:0] NegMax = Q_W'(1 << (NORMAL_BITS - 1));

  logic [2:0][NORMAL_BITS-1:0] comp_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [Q_W-1:0] q;
      q = dv_quo[i];
      if (dv_side.degen) begin
        comp_d[i] = '0;
      end else if (dv_side.neg[i]) begin
        if (q > NegMax) begin
          q = NegMax;
        end
        comp_d[i] = NORMAL_BITS'(-q);
      end else begin
        if (q > PosMax) begin
          q = PosMax;
        end
        comp_d[i] = q[NORMAL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_o.normal_x   <= comp_d[0];
      out_word_o.normal_y   <= comp_d[1];
      out_word_o.normal_z   <= comp_d[2];
      out_word_o.degenerate <= dv_side.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_valid;
    end
  end

  `TFN_ASSERT(a_degen_zero, (out_valid_o && out_word_o.degenerate) |-> (out_word_o.normal_x == '0 && out_word_o.normal_y == '0 && out_word_o.normal_z == '0), "degenerate word carries a nonzero normal")
  `TFN_ASSERT(a_normal_nonzero, (out_valid_o && !out_word_o.degenerate) |-> (out_word_o.normal_x != '0 || out_word_o.normal_y != '0 || out_word_o.normal_z != '0), "unit normal came out zero")
  `TFN_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a blocked output word")
endmodule
`default_nettype wire

[tb/triangle_face_normal_test.sv]
// Self-checking bench for triangle_face_normal: predicts each face normal and compares.
// Depends on tfn_pkg and the triangle_face_normal RTL; needs no other file.
`timescale 1ns / 1ps
module triangle_face_normal_test;
  import tfn_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  triangle_face_normal uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // The pipeline is 56 stages deep; the drain wait after the last word uses this.
  localparam int PIPE_DEPTH = 56;

  in_word_t  triangles_pending[$];
  out_word_t normals_expected[$];
  int        error_count = 0;
  bit        stimulus_done = 0;

  // Pressure controls shared between the initial block and the two clocked processes.
  bit        hold_receiver = 0;   // receiver stalls for a long counted stretch
  bit        hold_sender = 0;     // sender waits until nothing is outstanding
  int        hold_count = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Integer square root, bit by bit, floor of the true root.
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Works out the unit face normal of one triangle. The cross product is exact, the
  // magnitudes are brought into [2^23, 2^24) by one common shift, and each component
  // is divided by the length with rounding half away from zero, then saturated.
  function automatic out_word_t face_normal(in_word_t t);
    out_word_t        res;
    logic signed [63:0] e1[3];
    logic signed [63:0] e2[3];
    logic signed [63:0] cr[3];
    logic [63:0]      mag[3];
    logic [2:0]       neg;
    logic [63:0]      top;
    logic [63:0]      sumsq;
    logic [63:0]      len;
    logic [63:0]      quo;
    logic [NORMAL_BITS-1:0] comp[3];
    e1[0] = 64'(t.b_x) - 64'(t.a_x);
    e1[1] = 64'(t.b_y) - 64'(t.a_y);
    e1[2] = 64'(t.b_z) - 64'(t.a_z);
    e2[0] = 64'(t.c_x) - 64'(t.a_x);
    e2[1] = 64'(t.c_y) - 64'(t.a_y);
    e2[2] = 64'(t.c_z) - 64'(t.a_z);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    res = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    top = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? -cr[i] : cr[i];
      if (mag[i] > top) top = mag[i];
    end
    while (top >= (64'd1 << 24)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (top < (64'd1 << 23)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = root_floor(sumsq << 12);
    for (int i = 0; i < 3; i++) begin
      quo = ((mag[i] << (NORMAL_BITS + 6)) + len) / (2 * len);
      if (neg[i]) begin
        if (quo > (64'd1 << (NORMAL_BITS - 1))) quo = 64'd1 << (NORMAL_BITS - 1);
        comp[i] = NORMAL_BITS'(-quo);
      end else begin
        if (quo > (64'd1 << (NORMAL_BITS - 1)) - 1) quo = (64'd1 << (NORMAL_BITS - 1)) - 1;
        comp[i] = NORMAL_BITS'(quo);
      end
    end
    res.normal_x = comp[0];
    res.normal_y = comp[1];
    res.normal_z = comp[2];
    return res;
  endfunction

  // Random coordinate: mostly full range, sometimes a small value or an extreme, so
  // that both tiny and huge cross products show up.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return COORD_BITS'($signed($urandom_range(0, 64)) - 32);
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2: return {1'b1, {(COORD_BITS-1){1'b0}}};
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_triangle();
    in_word_t t;
    t.a_x = pick_coord(); t.a_y = pick_coord(); t.a_z = pick_coord();
    t.b_x = pick_coord(); t.b_y = pick_coord(); t.b_z = pick_coord();
    t.c_x = pick_coord(); t.c_y = pick_coord(); t.c_z = pick_coord();
    case ($urandom_range(0, 11))
      // Collinear: C = A + 2(B - A) keeps the cross product zero when C does not wrap.
      0: begin
        t.c_x = COORD_BITS'(t.a_x + 2 * (t.b_x - t.a_x));
        t.c_y = COORD_BITS'(t.a_y + 2 * (t.b_y - t.a_y));
        t.c_z = COORD_BITS'(t.a_z + 2 * (t.b_z - t.a_z));
      end
      // Two coincident vertices.
      1: t.b_x = t.a_x;
      default: ;
    endcase
    if (t.b_x == t.a_x) begin
      t.b_y = t.a_y;
      t.b_z = t.a_z;
    end
    return t;
  endfunction

  function automatic in_word_t make_triangle(int ax, int ay, int az, int bx, int by,
                                             int bz, int cx, int cy, int cz);
    in_word_t t;
    t.a_x = COORD_BITS'(ax); t.a_y = COORD_BITS'(ay); t.a_z = COORD_BITS'(az);
    t.b_x = COORD_BITS'(bx); t.b_y = COORD_BITS'(by); t.b_z = COORD_BITS'(bz);
    t.c_x = COORD_BITS'(cx); t.c_y = COORD_BITS'(cy); t.c_z = COORD_BITS'(cz);
    return t;
  endfunction

  // Driver. A word stays on the bus until accepted; bursts and gaps are random.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      automatic bit taken = in_valid_i && !in_stall_o;
      automatic bit offer;
      if (taken) begin
        normals_expected.push_back(face_normal(in_word_i));
      end
      if (in_valid_i && !taken) begin
        // Stalled word holds still.
      end else begin
        offer = 1'b0;
        if (hold_sender) begin
          offer = 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (triangles_pending.size() > 0) begin
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        if (offer) begin
          in_word_i <= triangles_pending.pop_front();
        end
        in_valid_i <= offer;
      end
    end
  end

  // Monitor and receiver. Stall follows its own random pattern, with quiet stretches,
  // and a long counted hold when asked.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      mode_left   <= 0;
      hold_count  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (normals_expected.size() == 0) begin
          $display("%0t: unexpected normal word %p", $time, out_word_o);
          error_count++;
        end else begin
          automatic out_word_t want = normals_expected.pop_front();
          if (out_word_o.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d got %0d", $time, want.normal_x,
                     out_word_o.normal_x);
            error_count++;
          end
          if (out_word_o.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d got %0d", $time, want.normal_y,
                     out_word_o.normal_y);
            error_count++;
          end
          if (out_word_o.normal_z !== want.normal_z) begin
            $display("%0t: normal_z expected %0d got %0d", $time, want.normal_z,
                     out_word_o.normal_z);
            error_count++;
          end
          if (out_word_o.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b got %0b", $time, want.degenerate,
                     out_word_o.degenerate);
            error_count++;
          end
        end
      end
      if (hold_receiver && hold_count < 150) begin
        hold_count  <= hold_count + 1;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_left  <= $urandom_range(5, 60);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  localparam int ONE = 1 << 16;
  localparam int MAXC = (1 << (COORD_BITS - 1)) - 1;
  localparam int MINC = -(1 << (COORD_BITS - 1));

  initial begin
    rst_ni = 1'b0;
    // Directed: axis-aligned normals give exactly +1.0 (saturated) and -1.0.
    triangles_pending.push_back(make_triangle(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    triangles_pending.push_back(make_triangle(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
    triangles_pending.push_back(make_triangle(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
    triangles_pending.push_back(make_triangle(0, 0, 0, 0, 0, ONE, 0, ONE, 0));
    triangles_pending.push_back(make_triangle(0, 0, 0, 0, 0, ONE, ONE, 0, 0));
    triangles_pending.push_back(make_triangle(0, 0, 0, ONE, 0, 0, 0, 0, ONE));
    // Degenerate: all vertices equal, all zero, and collinear.
    triangles_pending.push_back(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    triangles_pending.push_back(make_triangle(5, 6, 7, 5, 6, 7, 5, 6, 7));
    triangles_pending.push_back(make_triangle(0, 0, 0, 1, 2, 3, 2, 4, 6));
    // Coordinate extremes: largest edges and largest cross products.
    triangles_pending.push_back(make_triangle(MINC, MINC, MINC, MAXC, MINC, MINC,
                                              MINC, MAXC, MINC));
    triangles_pending.push_back(make_triangle(MAXC, MAXC, MAXC, MINC, MAXC, MAXC,
                                              MAXC, MINC, MAXC));
    triangles_pending.push_back(make_triangle(MINC, MAXC, MINC, MAXC, MINC, MAXC,
                                              MINC, MINC, MAXC));
    triangles_pending.push_back(make_triangle(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                              MINC, MINC, MINC));
    // Smallest non-zero cross product and two diagonal normals.
    triangles_pending.push_back(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
    triangles_pending.push_back(make_triangle(0, 0, 0, 1, -1, 0, 0, 1, -1));
    triangles_pending.push_back(make_triangle(-1, -1, -1, 0, 0, -1, -1, 0, 0));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Long receiver hold while the sender keeps offering words.
    for (int i = 0; i < 300; i++) triangles_pending.push_back(random_triangle());
    hold_receiver = 1'b1;
    wait (hold_count >= 150);
    hold_receiver = 1'b0;
    wait (triangles_pending.size() == 0);

    // Sender pauses until every outstanding normal has come back.
    @(posedge clk_i);
    hold_sender = 1'b1;
    wait (!in_valid_i && normals_expected.size() == 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    hold_sender = 1'b0;

    for (int i = 0; i < 500; i++) triangles_pending.push_back(random_triangle());
    wait (triangles_pending.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (normals_expected.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("triangle_face_normal_test: done, clean");
    end else begin
      $display("triangle_face_normal_test: done, errors");
    end
    $finish;
  end

  // Slowest run: about 820 words under random stall and gaps, well under 100 us.
  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("triangle_face_normal_test: done, errors");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_isqrt.sv
rtl/tfn_div.sv
rtl/triangle_face_normal.sv
tb/triangle_face_normal_test.sv
